FILE: rtl/core/atilt_pkg.sv
// Shared types, widths and the arctangent table of the tilt angle unit.
// Depends on nothing; used by every module of the block.
package atilt_pkg;

	// Radicand and root of the square root pipeline
	localparam int RAD_W  = 62;
	localparam int REM_W  = 33;
	localparam int ROOT_W = 31;
	// Scaled numerator and CORDIC datapath
	localparam int Y0_W   = 31;
	localparam int CX_W   = 34;
	localparam int CZ_W   = 32;
	// Result angle
	localparam int ANG_W  = 15;
	localparam int ANG_MAX = 9000;
	localparam int ROUND_HALF = 32768;
	localparam int Z_FRAC = 16;
	localparam int TAB_LEN = 24;

	// Side information that travels alongside the root
	typedef struct packed {
		logic [Y0_W-1:0] y0;       // numerator scaled by the root's fraction
		logic            neg;      // numerator below zero
		logic            nz;       // numerator not zero
		logic            den_zero; // sum of squares is zero
	} tag_t;

	// round(atan(2^-i) * 180/pi * 100 * 65536)
	function automatic logic [29:0] atan_entry(input int unsigned i);
		logic [29:0] v;
		case (i)
			0:  v = 30'd294912000;
			1:  v = 30'd174096719;
			2:  v = 30'd91987925;
			3:  v = 30'd46694507;
			4:  v = 30'd23437865;
			5:  v = 30'd11730358;
			6:  v = 30'd5866610;
			7:  v = 30'd2933484;
			8:  v = 30'd1466764;
			9:  v = 30'd733385;
			10: v = 30'd366693;
			11: v = 30'd183346;
			12: v = 30'd91673;
			13: v = 30'd45837;
			14: v = 30'd22918;
			15: v = 30'd11459;
			16: v = 30'd5730;
			17: v = 30'd2865;
			18: v = 30'd1432;
			19: v = 30'd716;
			20: v = 30'd358;
			21: v = 30'd179;
			22: v = 30'd90;
			23: v = 30'd45;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/accel_tilt_angles_unit.sv
// Tilt angles from a three-axis acceleration sample, three lanes side by side.
// Pipeline from accepted sample to result word:
// input register, squares, radicand, 31 root stages, ANGLE_STEPS rotations,
// rounding, output merge. Throughput: one word per cycle; the whole
// pipeline holds while a result waits on m_tready.
// Reset clears the valid and zero-flag pipelines only; data registers are not reset.
module accel_tilt_angles_unit #(
	parameter int SAMPLE_BITS = 16,
	parameter int ANGLE_STEPS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// accel_x, accel_y, accel_z from the lowest bit up, zero padded
	input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// pitch_angle, roll_angle, vertical_angle from the lowest bit up, zero padded
	output logic [((3*atilt_pkg::ANG_W+7)/8)*8-1:0]   m_tdata,
	// zero_vector
	output logic                                      m_tuser
);
	import atilt_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int LAT   = 36 + ANGLE_STEPS;
	localparam int OUT_W = ((3*ANG_W+7)/8)*8;

	logic                 en;
	logic [LAT-1:0]       vld_q;
	logic [LAT-1:0]       zf_q;
	logic signed [SB-1:0] ax_s1;
	logic signed [SB-1:0] ay_s1;
	logic signed [SB-1:0] az_s1;
	logic [ANG_W-1:0]     pitch;
	logic [ANG_W-1:0]     roll;
	logic [ANG_W-1:0]     vert;
	logic [OUT_W-1:0]     out_q;

	// advance the whole pipeline unless the result word is stalled
	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			zf_q  <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
			zf_q  <= {zf_q[LAT-2:0], (s_tdata[3*SB-1:0] == '0)};
		end
	end

	// capture the sample
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= s_tdata[SB-1:0];
			ay_s1 <= s_tdata[2*SB-1:SB];
			az_s1 <= s_tdata[3*SB-1:2*SB];
		end
	end

	atilt_lane #(.SAMPLE_BITS(SB), .STEPS(ANGLE_STEPS)) u_pitch (
		.clk(clk), .en(en), .num(ax_s1), .p(ay_s1), .q(az_s1), .angle(pitch)
	);

	atilt_lane #(.SAMPLE_BITS(SB), .STEPS(ANGLE_STEPS)) u_roll (
		.clk(clk), .en(en), .num(ay_s1), .p(ax_s1), .q(az_s1), .angle(roll)
	);

	atilt_lane #(.SAMPLE_BITS(SB), .STEPS(ANGLE_STEPS)) u_vert (
		.clk(clk), .en(en), .num(az_s1), .p(ax_s1), .q(ay_s1), .angle(vert)
	);

	// merge the lane angles into the result word
	always_ff @(posedge clk) begin
		if (en)
			out_q <= OUT_W'({vert, roll, pitch});
	end

	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = out_q;
	assign m_tuser  = zf_q[LAT-1];

`ifndef SYNTH
	// all-zero sample gives zero angles
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("zero sample with nonzero angles");

	// every angle lies within a quarter turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		($signed(m_tdata[ANG_W-1:0]) <= 15'sd9000) &&
		($signed(m_tdata[ANG_W-1:0]) >= -15'sd9000) &&
		($signed(m_tdata[2*ANG_W-1:ANG_W]) <= 15'sd9000) &&
		($signed(m_tdata[2*ANG_W-1:ANG_W]) >= -15'sd9000) &&
		($signed(m_tdata[3*ANG_W-1:2*ANG_W]) <= 15'sd9000) &&
		($signed(m_tdata[3*ANG_W-1:2*ANG_W]) >= -15'sd9000))
		else $error("angle out of range");

	// a stall freezes the valid pipeline
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q) && $stable(zf_q))
		else $error("pipeline moved during stall");
`endif

endmodule

FILE: rtl/core/atilt_sqrt.sv
// Pipelined integer square root, one root bit per stage, 31 stages.
// Depends on atilt_pkg for widths and the side tag type.
module atilt_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [atilt_pkg::RAD_W-1:0] rad,
	input  atilt_pkg::tag_t             tag_in,
	output logic [atilt_pkg::ROOT_W-1:0] root,
	output atilt_pkg::tag_t             tag_out
);
	import atilt_pkg::*;

	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	tag_t              tag_s  [ROOT_W];

	genvar k;
	generate
		for (k = 0; k < ROOT_W; k++) begin : g_stage
			logic [REM_W-1:0]  rem_i;
			logic [ROOT_W-1:0] root_i;
			logic [RAD_W-1:0]  rad_i;
			tag_t              tag_i;
			logic [REM_W+1:0]  acc;
			logic [REM_W+1:0]  trial;
			logic              ge;

			if (k == 0) begin : g_first
				assign rem_i  = '0;
				assign root_i = '0;
				assign rad_i  = rad;
				assign tag_i  = tag_in;
			end else begin : g_next
				assign rem_i  = rem_s[k-1];
				assign root_i = root_s[k-1];
				assign rad_i  = rad_s[k-1];
				assign tag_i  = tag_s[k-1];
			end

			// bring down the next two radicand bits and try the next root bit
			assign acc   = {rem_i, rad_i[RAD_W-1-2*k -: 2]};
			assign trial = {2'b00, root_i, 2'b01};
			assign ge    = (acc >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= ge ? REM_W'(acc - trial) : REM_W'(acc);
					root_s[k] <= {root_i[ROOT_W-2:0], ge};
					rad_s[k]  <= rad_i;
					tag_s[k]  <= tag_i;
				end
			end
		end
	endgenerate

	assign root    = root_s[ROOT_W-1];
	assign tag_out = tag_s[ROOT_W-1];

endmodule

FILE: rtl/core/atilt_cordic.sv
// Pipelined CORDIC vectoring, one rotation per stage, then rounding and clamp.
// Depends on atilt_pkg for widths, the tag type and the arctangent table.
module atilt_cordic #(
	parameter int STEPS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [atilt_pkg::ROOT_W-1:0] root,
	input  atilt_pkg::tag_t              tag_in,
	output logic [atilt_pkg::ANG_W-1:0]  angle
);
	import atilt_pkg::*;

	logic signed [CX_W-1:0] cx_s [STEPS];
	logic signed [CX_W-1:0] cy_s [STEPS];
	logic signed [CZ_W-1:0] cz_s [STEPS];
	tag_t                   tg_s [STEPS];
	logic [ANG_W-1:0]       angle_q;

	genvar i;
	generate
		for (i = 0; i < STEPS; i++) begin : g_rot
			logic signed [CX_W-1:0] x_i;
			logic signed [CX_W-1:0] y_i;
			logic signed [CZ_W-1:0] z_i;
			tag_t                   t_i;
			logic signed [CX_W-1:0] dx;
			logic signed [CX_W-1:0] dy;
			logic signed [CZ_W-1:0] step_a;

			if (i == 0) begin : g_first
				assign x_i = $signed({{(CX_W-ROOT_W){1'b0}}, root});
				assign y_i = $signed({{(CX_W-Y0_W){tag_in.y0[Y0_W-1]}}, tag_in.y0});
				assign z_i = '0;
				assign t_i = tag_in;
			end else begin : g_next
				assign x_i = cx_s[i-1];
				assign y_i = cy_s[i-1];
				assign z_i = cz_s[i-1];
				assign t_i = tg_s[i-1];
			end

			assign dx     = y_i >>> i;
			assign dy     = x_i >>> i;
			assign step_a = $signed({{(CZ_W-30){1'b0}}, atan_entry(i)});

			// rotate towards the x axis and accumulate the angle
			always_ff @(posedge clk) begin
				if (en) begin
					if (!y_i[CX_W-1]) begin
						cx_s[i] <= x_i + dx;
						cy_s[i] <= y_i - dy;
						cz_s[i] <= z_i + step_a;
					end else begin
						cx_s[i] <= x_i - dx;
						cy_s[i] <= y_i + dy;
						cz_s[i] <= z_i - step_a;
					end
					tg_s[i] <= t_i;
				end
			end
		end
	endgenerate

	// round half up, clamp to a quarter turn, settle a zero denominator
	logic signed [CZ_W-1:0] rnd;
	logic signed [CZ_W-1:0] clp;
	tag_t                   t_fin;

	assign t_fin = tg_s[STEPS-1];
	assign rnd   = (cz_s[STEPS-1] + CZ_W'(ROUND_HALF)) >>> Z_FRAC;

	always_comb begin
		if (t_fin.den_zero) begin
			if (!t_fin.nz)
				clp = '0;
			else if (t_fin.neg)
				clp = -CZ_W'(ANG_MAX);
			else
				clp = CZ_W'(ANG_MAX);
		end else if (rnd > CZ_W'(ANG_MAX)) begin
			clp = CZ_W'(ANG_MAX);
		end else if (rnd < -CZ_W'(ANG_MAX)) begin
			clp = -CZ_W'(ANG_MAX);
		end else begin
			clp = rnd;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			angle_q <= clp[ANG_W-1:0];
	end

	assign angle = angle_q;

endmodule

FILE: rtl/core/atilt_lane.sv
// One angle lane: squares, radicand build, square root and CORDIC.
// Depends on atilt_pkg, atilt_sqrt and atilt_cordic.
module atilt_lane #(
	parameter int SAMPLE_BITS = 16,
	parameter int STEPS       = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] num,
	input  logic signed [SAMPLE_BITS-1:0] p,
	input  logic signed [SAMPLE_BITS-1:0] q,
	output logic [atilt_pkg::ANG_W-1:0]   angle
);
	import atilt_pkg::*;

	localparam int FRAC = 31 - SAMPLE_BITS;
	localparam int SQ_W = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W = 2 * SAMPLE_BITS;

	logic signed [SAMPLE_BITS-1:0] num_s2;
	logic [SQ_W-1:0]               psq_s2;
	logic [SQ_W-1:0]               qsq_s2;
	logic [RAD_W-1:0]              rad_s3;
	tag_t                          tag_s3;
	logic signed [2*SAMPLE_BITS-1:0] pp;
	logic signed [2*SAMPLE_BITS-1:0] qq;
	logic [SUM_W-1:0]              sum;
	logic [ROOT_W-1:0]             root;
	tag_t                          tag_r;

	// square both denominator terms
	assign pp = p * p;
	assign qq = q * q;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= num;
			psq_s2 <= pp[SQ_W-1:0];
			qsq_s2 <= qq[SQ_W-1:0];
		end
	end

	// add the squares and scale radicand and numerator
	assign sum = {1'b0, psq_s2} + {1'b0, qsq_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3          <= {sum, {(RAD_W-SUM_W){1'b0}}};
			tag_s3.y0       <= {num_s2, {FRAC{1'b0}}};
			tag_s3.neg      <= num_s2[SAMPLE_BITS-1];
			tag_s3.nz       <= (num_s2 != '0);
			tag_s3.den_zero <= (sum == '0);
		end
	end

	atilt_sqrt u_sqrt (
		.clk     (clk),
		.en      (en),
		.rad     (rad_s3),
		.tag_in  (tag_s3),
		.root    (root),
		.tag_out (tag_r)
	);

	atilt_cordic #(.STEPS(STEPS)) u_cordic (
		.clk    (clk),
		.en     (en),
		.root   (root),
		.tag_in (tag_r),
		.angle  (angle)
	);

endmodule

FILE: verif/accel_tilt_angles_checker.sv
// Checker for the tilt angle unit: watches both stream channels, predicts
// each result word from the accepted sample and compares field by field.
// Depends on atilt_pkg for the angle width.
`timescale 1ns / 100ps
module accel_tilt_angles_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending
);
	import atilt_pkg::*;

	typedef struct packed {
		logic [ANG_W-1:0] pitch;
		logic [ANG_W-1:0] roll;
		logic [ANG_W-1:0] vert;
		logic             zero_vec;
	} angles_t;

	localparam int FRAC = 15;
	localparam int STEPS = 16;

	angles_t angle_queue[$];

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0) return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint int_root(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return longint'(res);
	endfunction

	// angle of num against the root of a^2 + b^2, hundredths of a degree
	function automatic logic [ANG_W-1:0] tilt_of(longint num, longint a, longint b);
		longint x, y, z, dx, dy, r;
		longint steps_tab[24];
		steps_tab = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
			5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
			22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
		x = int_root(longint'(a * a + b * b) << (2 * FRAC));
		y = num * (64'sd1 <<< FRAC);
		z = 0;
		if (x == 0) begin
			r = (num > 0) ? 9000 : (num < 0) ? -9000 : 0;
			return r[ANG_W-1:0];
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += steps_tab[i];
			end else begin
				x -= dx; y += dy; z -= steps_tab[i];
			end
		end
		r = floor_shift(z + 32768, 16);
		if (r > 9000) r = 9000;
		if (r < -9000) r = -9000;
		return r[ANG_W-1:0];
	endfunction

	function automatic angles_t predict_angles(logic [47:0] word);
		angles_t a;
		longint ax, ay, az;
		ax = longint'($signed(word[15:0]));
		ay = longint'($signed(word[31:16]));
		az = longint'($signed(word[47:32]));
		if (ax == 0 && ay == 0 && az == 0) begin
			a = '0;
			a.zero_vec = 1'b1;
			return a;
		end
		a.pitch = tilt_of(ax, ay, az);
		a.roll = tilt_of(ay, ax, az);
		a.vert = tilt_of(az, ax, ay);
		a.zero_vec = 1'b0;
		return a;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// predict on each accepted sample, compare each accepted result word
	always @(posedge clk) begin
		angles_t want;
		if (arst_n && s_tvalid && s_tready)
			angle_queue.push_back(predict_angles(s_tdata));
		if (arst_n && m_tvalid && m_tready) begin
			if (angle_queue.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = angle_queue.pop_front();
				if (m_tdata[14:0] !== want.pitch)
					report_mismatch("pitch", int'($signed(m_tdata[14:0])),
						int'($signed(want.pitch)));
				if (m_tdata[29:15] !== want.roll)
					report_mismatch("roll", int'($signed(m_tdata[29:15])),
						int'($signed(want.roll)));
				if (m_tdata[44:30] !== want.vert)
					report_mismatch("vertical", int'($signed(m_tdata[44:30])),
						int'($signed(want.vert)));
				if (m_tuser !== want.zero_vec)
					report_mismatch("zero_vector", int'(m_tuser), int'(want.zero_vec));
			end
		end
		pending = angle_queue.size();
	end
endmodule

FILE: verif/tb_accel_tilt_angles_unit.sv
// Testbench top for the tilt angle unit: drives samples with random gaps and
// stalls, gives the verdict. Depends on accel_tilt_angles_checker and the RTL.
`timescale 1ns / 100ps
module tb_accel_tilt_angles_unit;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	int          fail_count;
	int          pending;
	bit          quiet_phase;
	bit          hold_sink;
	bit          stim_done;

	accel_tilt_angles_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	accel_tilt_angles_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, with a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_sink) m_tready <= 1'b0;
			else if (quiet_phase) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(99) >= 30);
		end
	end

	initial begin
		hold_sink = 1'b0;
		wait (stim_done == 1'b0 && arst_n === 1'b1);
		repeat (150) @(posedge clk);
		hold_sink = 1'b1;
		repeat (200) @(posedge clk);
		hold_sink = 1'b0;
	end

	// offer one sample and hold it until accepted; idle gaps drop tvalid
	task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		while (!quiet_phase && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(5))
			0: return 16'(($urandom_range(64)) - 32);
			1: return 16'h8000;
			2: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] edge_vals[6];
		edge_vals = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h4000};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		quiet_phase = 1'b0;
		stim_done = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		// directed: all-zero sample, single-axis samples, extremes
		send_sample(16'h0000, 16'h0000, 16'h0000);
		for (int i = 1; i < 6; i++) begin
			send_sample(edge_vals[i], 16'h0000, 16'h0000);
			send_sample(16'h0000, edge_vals[i], 16'h0000);
			send_sample(16'h0000, 16'h0000, edge_vals[i]);
		end
		send_sample(16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff);
		send_sample(16'h7fff, 16'h8000, 16'h0001);
		// pause until all results are back
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// random, with a stretch with no idling
		for (int n = 0; n < 400; n++) begin
			quiet_phase = (n >= 250 && n < 320);
			send_sample(rand_axis(), rand_axis(), rand_axis());
		end
		s_tvalid <= 1'b0;
		quiet_phase = 1'b0;
		stim_done = 1'b1;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
